@@ rtl/first_fit_range_allocator_defines.svh @@
// assertion macros shared by the checker
`ifndef FIRST_FIT_RANGE_ALLOCATOR_DEFINES_SVH
`define FIRST_FIT_RANGE_ALLOCATOR_DEFINES_SVH

// same-cycle implication
`define FFRA_ASSERT_NOW(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
      else $error("ffra check failed");

// next-cycle implication
`define FFRA_ASSERT_NEXT(lbl, clk, rst, a, c) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
      else $error("ffra check failed");

`endif

@@ rtl/ffra_pkg.sv @@
package ffra_pkg;

   localparam int MaxBlocksDefault = 32;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NOSPACE = 2'd1;
   localparam logic [1:0] ST_BADOFF  = 2'd2;
   localparam logic [1:0] ST_FULL    = 2'd3;

   localparam logic FUNC_ALLOC = 1'b0;
   localparam logic FUNC_FREE  = 1'b1;

   localparam logic [1:0] ADDR_TOTAL_SIZE = 2'd0;

   typedef struct packed {
      logic [31:0] len;
      logic        free;
   } entry_type;

endpackage

@@ rtl/first_fit_range_allocator.sv @@
// The block table lives in a chain of MAX_BLOCKS cells that is rotated once through the
// sequencer per request, one block a cycle, while the sequencer matches, splits, appends
// or frees in the stream; the result is then shown for one cycle. start is taken only
// while busy is low; the result is on the rsp_ ports for one cycle under rsp_valid and
// must be taken then. total_size must be written over the APB-style port only while the
// block is idle; the block itself does not enforce this.
module first_fit_range_allocator #(
   parameter int MAX_BLOCKS = ffra_pkg::MaxBlocksDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_func,
   input  logic [31:0] req_size,
   input  logic [31:0] req_offset,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_alloc_offset,
   output logic [31:0] rsp_max_allocation,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [1:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int IW = $clog2(MAX_BLOCKS);
   localparam int CW = $clog2(MAX_BLOCKS + 1);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RUN  = 2'd1;
   localparam logic [1:0] S_RESP = 2'd2;

   logic [1:0]  state_ff, state_in;
   logic [31:0] total_ff, total_in;
   logic [CW-1:0] count_ff, count_in, newcnt_ff, newcnt_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic        done_ff, done_in, carry_v_ff, carry_v_in;
   ffra_pkg::entry_type carry_ff, carry_in;
   logic [1:0]  status_ff, status_in;
   logic [31:0] grant_ff, grant_in, off_ff, off_in, max_ff, max_in;
   logic [32:0] sum_ff, sum_in;
   logic        func_ff, func_in;
   logic [31:0] size_ff, size_in, offset_ff, offset_in;

   ffra_pkg::entry_type chain [MAX_BLOCKS];
   ffra_pkg::entry_type push, pop;
   logic        shift_en;

   assign shift_en = (state_ff == S_RUN);
   assign pop = chain[MAX_BLOCKS-1];

   for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
      if (k == 0) begin : g_head
         ffra_cell u_cell (.clock(clock), .shift_en(shift_en), .d(push), .q(chain[k]));
      end else begin : g_body
         ffra_cell u_cell (.clock(clock), .shift_en(shift_en), .d(chain[k-1]), .q(chain[k]));
      end
   end

   logic          pvalid, first_inv, pushv, grow;
   logic [31:0]   tail_cur, tail_end, tail_new;
   logic [CW-1:0] newcnt;
   logic [CW-1:0] idx_ext;

   always_comb begin
      state_in   = state_ff;
      total_in   = total_ff;
      count_in   = count_ff;
      newcnt_in  = newcnt_ff;
      idx_in     = idx_ff;
      done_in    = done_ff;
      carry_v_in = carry_v_ff;
      carry_in   = carry_ff;
      status_in  = status_ff;
      grant_in   = grant_ff;
      off_in     = off_ff;
      max_in     = max_ff;
      sum_in     = sum_ff;
      func_in    = func_ff;
      size_in    = size_ff;
      offset_in  = offset_ff;
      grow       = 1'b0;
      idx_ext    = CW'(idx_ff);
      pvalid     = idx_ext < count_ff;
      first_inv  = idx_ext == count_ff;
      tail_cur   = (total_ff > off_ff) ? (total_ff - off_ff) : 32'd0;
      push       = carry_v_ff ? carry_ff : pop;
      newcnt     = newcnt_ff;
      pushv      = 1'b0;
      tail_end   = 32'd0;
      tail_new   = ({1'b0, total_ff} > sum_ff) ? (total_ff - sum_ff[31:0]) : 32'd0;

      if (psel && penable && pwrite && (paddr == ffra_pkg::ADDR_TOTAL_SIZE)) begin
         total_in = pwdata;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in   = S_RUN;
               func_in    = req_func;
               size_in    = req_size;
               offset_in  = req_offset;
               idx_in     = '0;
               done_in    = 1'b0;
               carry_v_in = 1'b0;
               status_in  = ffra_pkg::ST_OK;
               grant_in   = 32'd0;
               off_in     = 32'd0;
               sum_in     = 33'd0;
               max_in     = 32'd0;
               newcnt_in  = count_ff;
            end
         end
         S_RUN: begin
            // a pending split remainder delays the rest of the stream by one cell
            if (carry_v_ff) begin
               carry_in = pop;
            end
            if (!done_ff && !carry_v_ff) begin
               if (func_ff == ffra_pkg::FUNC_ALLOC) begin
                  if (pvalid && pop.free && (pop.len >= size_ff)) begin
                     done_in = 1'b1;
                     if (pop.len == size_ff) begin
                        push.free = 1'b0;
                        grant_in  = off_ff;
                     end else if (count_ff < CW'(MAX_BLOCKS)) begin
                        push.len   = size_ff;
                        push.free  = 1'b0;
                        carry_in.len  = pop.len - size_ff;
                        carry_in.free = 1'b1;
                        carry_v_in = 1'b1;
                        grow       = 1'b1;
                        grant_in   = off_ff;
                     end else begin
                        status_in = ffra_pkg::ST_FULL;
                     end
                  end else if (first_inv) begin
                     done_in = 1'b1;
                     if (tail_cur < size_ff) begin
                        status_in = ffra_pkg::ST_NOSPACE;
                     end else begin
                        push.len  = size_ff;
                        push.free = 1'b0;
                        grow      = 1'b1;
                        grant_in  = off_ff;
                     end
                  end
               end else if (pvalid && (off_ff == offset_ff)) begin
                  push.free = 1'b1;
                  done_in   = 1'b1;
               end
            end
            if (pvalid) begin
               off_in = off_ff + pop.len;
            end
            newcnt    = newcnt_ff + CW'(grow);
            newcnt_in = newcnt;
            pushv     = idx_ext < newcnt;
            if (pushv) begin
               sum_in = sum_ff + {1'b0, push.len};
               if (push.free && (push.len > max_ff)) begin
                  max_in = push.len;
               end
            end
            idx_in = idx_ff + IW'(1);
            if (idx_ff == IW'(MAX_BLOCKS - 1)) begin
               state_in = S_RESP;
               // no decision in the pass: full table or no matching offset
               tail_end = (total_ff > off_in) ? (total_ff - off_in) : 32'd0;
               if (!done_in) begin
                  if (func_ff == ffra_pkg::FUNC_ALLOC) begin
                     status_in = (tail_end < size_ff) ? ffra_pkg::ST_NOSPACE
                                                      : ffra_pkg::ST_FULL;
                  end else begin
                     status_in = ffra_pkg::ST_BADOFF;
                  end
               end
            end
         end
         S_RESP: begin
            count_in = newcnt_ff;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         total_ff <= 32'd0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         total_ff <= total_in;
         count_ff <= count_in;
      end
      newcnt_ff  <= newcnt_in;
      idx_ff     <= idx_in;
      done_ff    <= done_in;
      carry_v_ff <= carry_v_in;
      carry_ff   <= carry_in;
      status_ff  <= status_in;
      grant_ff   <= grant_in;
      off_ff     <= off_in;
      max_ff     <= max_in;
      sum_ff     <= sum_in;
      func_ff    <= func_in;
      size_ff    <= size_in;
      offset_ff  <= offset_in;
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_valid          = (state_ff == S_RESP);
   assign rsp_status         = status_ff;
   assign rsp_alloc_offset   = grant_ff;
   assign rsp_max_allocation = (max_ff > tail_new) ? max_ff : tail_new;
   assign prdata             = (paddr == ffra_pkg::ADDR_TOTAL_SIZE) ? total_ff : 32'd0;
   assign pready             = 1'b1;

endmodule

@@ rtl/ffra_cell.sv @@
module ffra_cell (
   input  logic                clock,
   input  logic                shift_en,
   input  ffra_pkg::entry_type d,
   output ffra_pkg::entry_type q
);

   ffra_pkg::entry_type q_ff;
   ffra_pkg::entry_type q_in;

   always_comb begin
      q_in = shift_en ? d : q_ff;
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
   end

   assign q = q_ff;

endmodule

@@ rtl/ffra_checker.sv @@
`include "first_fit_range_allocator_defines.svh"

module ffra_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [1:0]  rsp_status,
   input logic [31:0] rsp_alloc_offset
);

   logic rsp_fail;

   assign rsp_fail = rsp_valid && (rsp_status != ffra_pkg::ST_OK);

   `FFRA_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy, busy)
   `FFRA_ASSERT_NEXT(a_rsp_single, clock, reset, rsp_valid, !rsp_valid)
   `FFRA_ASSERT_NOW(a_rsp_busy, clock, reset, rsp_valid, busy)
   `FFRA_ASSERT_NOW(a_fail_zero, clock, reset, rsp_fail, rsp_alloc_offset == 32'd0)

endmodule

bind first_fit_range_allocator ffra_checker u_ffra_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_valid(rsp_valid),
   .rsp_status(rsp_status),
   .rsp_alloc_offset(rsp_alloc_offset)
);
